FILE: hw/rtl/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

  // request and result field widths
  localparam int VALUE_W = 16;
  localparam int SEL_W   = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // free-slot search examines this many slots per cycle
  localparam int SCAN_LANES = 8;

  // kind of result written to the output register
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_EMPTY,
    RES_FULL,
    RES_POP
  } sps_res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic          load;       // capture the accepted request
    logic          mem_rd;     // read the slot under the selected top
    logic          push_write; // write slot, link it in, restart search after it
    logic          use_found;  // push slot comes from the search, not alloc pointer
    logic          scan_alloc; // start search at the allocation pointer
    logic          scan_step;  // advance the search by one group
    logic          alloc_set;  // update allocation pointer from search result, or the written slot if none
    logic          pop_commit; // free the top slot and follow its link
    logic          out_load;   // load the output register
    sps_res_kind_t res_kind;
  } sps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sel_ok;
    logic is_pop;
    logic top_null;
    logic pool_full;
    logic alloc_free;
    logic found;
    logic exhausted;
  } sps_sts_t;

endpackage

FILE: hw/rtl/sps_in_if.sv
`timescale 1ns / 1ps

interface sps_in_if import sps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [SEL_W-1:0]   stack_sel;
  logic [VALUE_W-1:0] push_value;

  modport source (output valid, output op, output stack_sel, output push_value,
                  input ready);
  modport sink   (input valid, input op, input stack_sel, input push_value,
                  output ready);
endinterface

FILE: hw/rtl/sps_out_if.sv
`timescale 1ns / 1ps

interface sps_out_if import sps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] pop_value;
  logic               stack_empty;
  logic               pool_full;

  modport source (output valid, output pop_value, output stack_empty, output pool_full,
                  input ready);
  modport sink   (input valid, input pop_value, input stack_empty, input pool_full,
                  output ready);
endinterface

FILE: hw/rtl/sps_dp.sv
`timescale 1ns / 1ps

module sps_dp import sps_pkg::*; #(
  parameter int POOL_DEPTH = 128,
  parameter int NUM_STACKS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_op,
  input  logic [SEL_W-1:0]   req_stack_sel,
  input  logic [VALUE_W-1:0] req_push_value,
  input  sps_cmd_t           cmd,
  output sps_sts_t           sts,
  output logic [VALUE_W-1:0] res_pop_value,
  output logic               res_stack_empty,
  output logic               res_pool_full
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int STK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int LANES = (POOL_DEPTH < SCAN_LANES) ? POOL_DEPTH : SCAN_LANES;
  localparam int MEM_W = PTR_W + VALUE_W;

  localparam logic [PTR_W-1:0] NULL_P  = PTR_W'(POOL_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);
  localparam logic [CNT_W-1:0] LANES_C = CNT_W'(LANES);

  // circular wrap of a position below twice the depth
  function automatic logic [IDX_W-1:0] wrap_pos(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p >= NULL_P) ? (p - NULL_P) : p;
    return q[IDX_W-1:0];
  endfunction

  // request capture
  logic               req_op_r;
  logic [SEL_W-1:0]   req_sel_r;
  logic [VALUE_W-1:0] req_value_r;

  // stack state
  logic [PTR_W-1:0]      tops_r [NUM_STACKS];
  logic [POOL_DEPTH-1:0] occ_r;
  logic [IDX_W-1:0]      alloc_r;
  logic [CNT_W-1:0]      used_r;

  // search and slot memory
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] scan_pos_r;
  logic [CNT_W-1:0] scan_rem_r;
  logic [MEM_W-1:0] slot_mem_r [POOL_DEPTH];
  logic [MEM_W-1:0] rd_data_r;

  // output register
  logic [VALUE_W-1:0] out_value_r;
  logic               out_empty_r;
  logic               out_full_r;

  logic               sel_ok;
  logic [STK_W-1:0]   sel_idx;
  logic [PTR_W-1:0]   cur_top;
  logic [IDX_W-1:0]   top_idx;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   lane_pos [LANES];
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic [PTR_W-1:0]   rd_link;
  logic [VALUE_W-1:0] rd_value;

  // selected stack
  assign sel_ok  = (32'(req_sel_r) < NUM_STACKS);
  assign sel_idx = STK_W'(req_sel_r);
  assign cur_top = sel_ok ? tops_r[sel_idx] : NULL_P;
  assign top_idx = cur_top[IDX_W-1:0];
  assign slot    = cmd.use_found ? found_idx : alloc_r;
  assign rd_link  = rd_data_r[MEM_W-1:VALUE_W];
  assign rd_value = rd_data_r[VALUE_W-1:0];

  // one group of slots per cycle, first free slot from the search position wins
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_pos[i] = wrap_pos({1'b0, scan_pos_r} + PTR_W'(i));
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = scan_pos_r;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (!occ_r[lane_pos[i]] && (CNT_W'(i) < scan_rem_r)) begin
        found     = 1'b1;
        found_idx = lane_pos[i];
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.sel_ok     = sel_ok;
    sts.is_pop     = (req_op_r == OP_POP);
    sts.top_null   = (cur_top >= NULL_P);
    sts.pool_full  = (used_r >= DEPTH_C);
    sts.alloc_free = !occ_r[alloc_r];
    sts.found      = found;
    sts.exhausted  = !found && (scan_rem_r <= LANES_C);
  end

  // stack tops, occupancy map, allocation pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        tops_r[s] <= NULL_P;
      end
      occ_r   <= '0;
      alloc_r <= '0;
      used_r  <= '0;
    end else begin
      if (cmd.push_write) begin
        occ_r[slot]     <= 1'b1;
        tops_r[sel_idx] <= {1'b0, slot};
        used_r          <= used_r + 1'b1;
      end
      if (cmd.pop_commit) begin
        occ_r[top_idx]  <= 1'b0;
        tops_r[sel_idx] <= (rd_link >= NULL_P) ? NULL_P : rd_link;
        if (occ_r[top_idx] && (used_r != '0)) begin
          used_r <= used_r - 1'b1;
        end
      end
      if (cmd.alloc_set) begin
        alloc_r <= found ? found_idx : slot_r;
      end
    end
  end

  // request capture and search position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op_r    <= req_op;
      req_sel_r   <= req_stack_sel;
      req_value_r <= req_push_value;
    end
    if (cmd.push_write) begin
      slot_r     <= slot;
      scan_pos_r <= wrap_pos({1'b0, slot} + PTR_W'(1));
      scan_rem_r <= DEPTH_C;
    end else if (cmd.scan_alloc) begin
      scan_pos_r <= alloc_r;
      scan_rem_r <= DEPTH_C;
    end else if (cmd.scan_step) begin
      scan_pos_r <= wrap_pos({1'b0, scan_pos_r} + PTR_W'(LANES));
      scan_rem_r <= (scan_rem_r > LANES_C) ? (scan_rem_r - LANES_C) : '0;
    end
  end

  // slot memory: value and link below
  always_ff @(posedge clk) begin
    if (cmd.push_write) begin
      slot_mem_r[slot] <= {cur_top, req_value_r};
    end
    if (cmd.mem_rd) begin
      rd_data_r <= slot_mem_r[top_idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_kind)
        RES_POP: begin
          out_value_r <= rd_value;
          out_empty_r <= 1'b0;
          out_full_r  <= 1'b0;
        end
        RES_EMPTY: begin
          out_value_r <= '0;
          out_empty_r <= 1'b1;
          out_full_r  <= 1'b0;
        end
        RES_FULL: begin
          out_value_r <= '0;
          out_empty_r <= 1'b0;
          out_full_r  <= 1'b1;
        end
        default: begin
          out_value_r <= '0;
          out_empty_r <= 1'b0;
          out_full_r  <= 1'b0;
        end
      endcase
    end
  end

  assign res_pop_value   = out_value_r;
  assign res_stack_empty = out_empty_r;
  assign res_pool_full   = out_full_r;

endmodule

FILE: hw/rtl/sps_ctrl.sv
`timescale 1ns / 1ps

module sps_ctrl import sps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  sps_sts_t sts,
  output sps_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_SLOT,
    ST_SCAN_NEXT,
    ST_POP_RD,
    ST_HOLD
  } state_t;

  state_t        state_r, state_nxt;
  logic          in_ready_r, in_ready_nxt;
  logic          out_valid_r, out_valid_nxt;
  sps_res_kind_t res_kind_r, res_kind_nxt;

  logic          fin;
  sps_res_kind_t fin_kind;
  logic          out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    res_kind_nxt = res_kind_r;
    cmd          = '0;
    cmd.res_kind = RES_ZERO;
    fin          = 1'b0;
    fin_kind     = RES_ZERO;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load     = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts.sel_ok) begin
          fin = 1'b1;
        end else if (sts.is_pop) begin
          if (sts.top_null) begin
            fin      = 1'b1;
            fin_kind = RES_EMPTY;
          end else begin
            cmd.mem_rd = 1'b1;
            state_nxt  = ST_POP_RD;
          end
        end else if (sts.pool_full) begin
          fin      = 1'b1;
          fin_kind = RES_FULL;
        end else if (sts.alloc_free) begin
          cmd.push_write = 1'b1;
          state_nxt      = ST_SCAN_NEXT;
        end else begin
          cmd.scan_alloc = 1'b1;
          state_nxt      = ST_SCAN_SLOT;
        end
      end
      // search for the slot to write
      ST_SCAN_SLOT: begin
        if (sts.found) begin
          cmd.push_write = 1'b1;
          cmd.use_found  = 1'b1;
          state_nxt      = ST_SCAN_NEXT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      // search for the next free slot after the one written
      ST_SCAN_NEXT: begin
        if (sts.found || sts.exhausted) begin
          cmd.alloc_set = 1'b1;
          fin           = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_POP_RD: begin
        cmd.pop_commit = 1'b1;
        fin            = 1'b1;
        fin_kind       = RES_POP;
      end
      ST_HOLD: begin
        fin      = 1'b1;
        fin_kind = res_kind_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand the result to the output register, or park it
    if (fin) begin
      if (out_free) begin
        cmd.out_load = 1'b1;
        cmd.res_kind = fin_kind;
        in_ready_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end else begin
        res_kind_nxt = fin_kind;
        state_nxt    = ST_HOLD;
      end
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
      res_kind_r  <= RES_ZERO;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
      res_kind_r  <= res_kind_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/shared_pool_multi_stack.sv
`timescale 1ns / 1ps

// NUM_STACKS LIFO stacks sharing one pool of POOL_DEPTH slots. Each request is a push of
// push_value or a pop of the stack named by stack_sel and gives exactly one result: the
// popped value, or stack_empty for a pop of an empty stack, or pool_full for a push with
// no free slot; a stack_sel beyond the last stack changes nothing and returns all zeros.
// One request is worked on at a time. A pop issues the registered read of the slot memory,
// then frees the top slot and loads the popped value. A push writes its slot, then the
// free-slot search runs on from it in groups of 8 slots, covering up to POOL_DEPTH/8
// groups once the pool is nearly full; when the allocation pointer sits on an occupied
// slot, a first search in the same groups finds the slot to write. The search examines 8
// entries of the occupancy map per cycle. The next request is taken while a result
// still waits in the output register; a finished result waits only when that register
// is still occupied. Reset clears the occupancy map at once, so no clearing pass follows.
module shared_pool_multi_stack import sps_pkg::*; #(
  parameter int POOL_DEPTH = 128,
  parameter int NUM_STACKS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  sps_in_if.sink           in_ch,
  sps_out_if.source        out_ch
);

  sps_cmd_t cmd;
  sps_sts_t sts;

  // controller
  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  sps_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_STACKS (NUM_STACKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_op          (in_ch.op),
    .req_stack_sel   (in_ch.stack_sel),
    .req_push_value  (in_ch.push_value),
    .cmd             (cmd),
    .sts             (sts),
    .res_pop_value   (out_ch.pop_value),
    .res_stack_empty (out_ch.stack_empty),
    .res_pool_full   (out_ch.pool_full)
  );

  // a push never writes into a full pool
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_write |-> !sts.pool_full)
    else $error("push write with pool full");

  // a slot taken straight from the allocation pointer must be free
  a_alloc_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_write && !cmd.use_found) |-> sts.alloc_free)
    else $error("push into occupied allocation slot");

  // a pop only commits against a non-empty stack
  a_pop_has_top: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_commit |-> (sts.sel_ok && !sts.top_null))
    else $error("pop commit on empty stack");

  // the output register is never overwritten while its result is pending
  a_out_not_clobbered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sps_pkg::*;

  localparam int SLOTS      = 128;
  localparam int STACKS     = 3;
  localparam int LIVE_ITEMS = 1550;
  localparam int HOLD_LEN   = 300;
  localparam logic [SEL_W-1:0] SPARE_SEL = 2'd3;

  typedef struct {
    logic               op;
    logic [SEL_W-1:0]   sel;
    logic [VALUE_W-1:0] value;
    bit                 drain_first;
  } stack_req_t;

  typedef struct {
    logic [VALUE_W-1:0] popped;
    logic               empty;
    logic               full;
  } stack_res_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_CHURN} phase_t;

  logic clk;
  logic rst_n;

  sps_in_if  in_ch ();
  sps_out_if out_ch ();

  shared_pool_multi_stack #(
    .POOL_DEPTH (SLOTS),
    .NUM_STACKS (STACKS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the pool
  logic [VALUE_W-1:0] slot_val  [SLOTS];
  int                 slot_link [SLOTS];
  bit                 slot_busy [SLOTS];
  int                 top_of    [STACKS] = '{default: SLOTS};
  int                 alloc_at   = 0;
  int                 slots_used = 0;

  stack_req_t req_backlog [$];
  stack_res_t due_results [$];

  bit req_fired     = 0;
  int taken_count   = 0;
  int mismatches    = 0;
  int send_gap      = 0;
  int send_calm     = 0;
  int recv_stall    = 0;
  int recv_calm     = 0;
  int hold_left     = 0;
  int hold_mark     = 300;

  // request generator bookkeeping
  int gen_depth [STACKS] = '{default: 0};
  int gen_used  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // first free slot scanning circularly from a start slot, SLOTS when none
  function automatic int first_free(int from);
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_busy[(from + i) % SLOTS]) return (from + i) % SLOTS;
    end
    return SLOTS;
  endfunction

  // apply one request to the mirror and return the result it must give
  function automatic stack_res_t stack_op_outcome(stack_req_t r);
    stack_res_t res;
    int         slot;
    int         nxt;
    int         t;
    res = '{default: 0};
    if (r.sel < STACKS) begin
      if (r.op == OP_PUSH) begin
        slot = (slots_used < SLOTS) ? first_free(alloc_at) : SLOTS;
        if (slot == SLOTS) begin
          res.full = 1'b1;
        end else begin
          slot_val[slot]  = r.value;
          slot_link[slot] = top_of[r.sel];
          slot_busy[slot] = 1'b1;
          top_of[r.sel]   = slot;
          slots_used++;
          nxt      = first_free((slot + 1) % SLOTS);
          alloc_at = (nxt < SLOTS) ? nxt : slot;
        end
      end else begin
        t = top_of[r.sel];
        if (t >= SLOTS) begin
          res.empty = 1'b1;
        end else begin
          res.popped = slot_val[t];
          if (slot_busy[t] && slots_used > 0) slots_used--;
          slot_busy[t]  = 1'b0;
          top_of[r.sel] = (slot_link[t] < SLOTS) ? slot_link[t] : SLOTS;
        end
      end
    end
    return res;
  endfunction

  // idle length: mostly none, some short, a few long, with calm stretches
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VALUE_W'($urandom);
  endfunction

  task automatic queue_req(logic op, logic [SEL_W-1:0] sel, logic [VALUE_W-1:0] value,
                           bit drain_first);
    stack_req_t r;
    r.op          = op;
    r.sel         = sel;
    r.value       = value;
    r.drain_first = drain_first;
    req_backlog.push_back(r);
    // rough occupancy tracking, only to shape the sequences
    if (sel < STACKS) begin
      if (op == OP_PUSH && gen_used < SLOTS) begin
        gen_depth[sel]++;
        gen_used++;
      end else if (op == OP_POP && gen_depth[sel] > 0) begin
        gen_depth[sel]--;
        gen_used--;
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin : drv
    stack_req_t nxt;
    logic       drive;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.op         <= OP_PUSH;
      in_ch.stack_sel  <= '0;
      in_ch.push_value <= '0;
    end else if (!in_ch.valid || req_fired) begin
      drive = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (req_backlog.size() > 0 &&
                   !(req_backlog[0].drain_first && due_results.size() > 0)) begin
        nxt              = req_backlog.pop_front();
        drive            = 1'b1;
        in_ch.op         <= nxt.op;
        in_ch.stack_sel  <= nxt.sel;
        in_ch.push_value <= nxt.value;
        send_gap         = pick_idle(send_calm);
      end
      in_ch.valid <= drive;
    end
  end

  // result receiver readiness, with long hold-offs to back the block up
  always @(negedge clk) begin : rcv
    logic rdy;
    rdy = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
    end else if (taken_count >= hold_mark) begin
      hold_left = HOLD_LEN;
      hold_mark = hold_mark + 700;
    end else if (recv_stall > 0) begin
      recv_stall--;
    end else begin
      rdy        = 1'b1;
      recv_stall = pick_idle(recv_calm);
    end
    out_ch.ready <= rst_n ? rdy : 1'b0;
  end

  // monitor: check results, then predict for the request taken at this edge
  always @(posedge clk) begin : mon
    stack_res_t want;
    stack_req_t got_req;
    if (!rst_n) begin
      req_fired = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result pop_value=%h stack_empty=%b pool_full=%b",
                   $time, out_ch.pop_value, out_ch.stack_empty, out_ch.pool_full);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_ch.pop_value !== want.popped || out_ch.stack_empty !== want.empty ||
              out_ch.pool_full !== want.full) begin
            $display("%0t: expected pop_value=%h stack_empty=%b pool_full=%b, got %h %b %b",
                     $time, want.popped, want.empty, want.full,
                     out_ch.pop_value, out_ch.stack_empty, out_ch.pool_full);
            mismatches++;
          end
        end
      end
      req_fired = in_ch.valid && in_ch.ready;
      if (req_fired) begin
        got_req.op          = in_ch.op;
        got_req.sel         = in_ch.stack_sel;
        got_req.value       = in_ch.push_value;
        got_req.drain_first = 1'b0;
        due_results.push_back(stack_op_outcome(got_req));
        taken_count++;
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

  // stimulus and end of run
  initial begin : stim
    phase_t          kind;
    int              len;
    int              push_pct;
    bit              drain;
    logic [SEL_W-1:0] sel;
    logic            op;
    rst_n            = 1'b0;

    // directed: empty pops, spare selector, value extremes, lifo order
    queue_req(OP_POP, 2'd0, '0, 1'b0);
    queue_req(OP_POP, 2'd1, '0, 1'b0);
    queue_req(OP_POP, 2'd2, '0, 1'b0);
    queue_req(OP_PUSH, SPARE_SEL, '1, 1'b0);
    queue_req(OP_POP, SPARE_SEL, '0, 1'b0);
    queue_req(OP_PUSH, 2'd0, 16'h0000, 1'b0);
    queue_req(OP_PUSH, 2'd1, 16'hffff, 1'b0);
    queue_req(OP_PUSH, 2'd2, 16'h5555, 1'b0);
    queue_req(OP_PUSH, 2'd0, 16'haaaa, 1'b0);
    queue_req(OP_PUSH, 2'd2, 16'h8001, 1'b0);
    queue_req(OP_POP, 2'd0, '1, 1'b0);
    queue_req(OP_POP, 2'd0, '0, 1'b0);
    queue_req(OP_POP, 2'd0, '0, 1'b0);
    queue_req(OP_POP, 2'd1, '0, 1'b0);
    queue_req(OP_POP, 2'd2, '0, 1'b0);
    queue_req(OP_POP, 2'd2, '0, 1'b0);
    queue_req(OP_POP, 2'd2, '0, 1'b0);
    queue_req(OP_PUSH, 2'd1, 16'h7ffe, 1'b0);
    queue_req(OP_POP, 2'd1, '0, 1'b0);

    // fill the pool past full after a drained pause, then free scattered slots and refill them
    for (int i = 0; i < SLOTS + 8; i++)
      queue_req(OP_PUSH, SEL_W'($urandom_range(0, STACKS - 1)), rand_value(), i == 0);
    for (int i = 0; i < 6; i++)
      queue_req(OP_POP, SEL_W'($urandom_range(0, STACKS - 1)), '0, 1'b0);
    for (int i = 0; i < 9; i++)
      queue_req(OP_PUSH, SEL_W'($urandom_range(0, STACKS - 1)), rand_value(), 1'b0);

    // random phases with different push/pop balance
    while (req_backlog.size() < LIVE_ITEMS) begin
      kind  = phase_t'($urandom_range(0, 3));
      len   = $urandom_range(30, 150);
      drain = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len && req_backlog.size() < LIVE_ITEMS; k++) begin
        sel = ($urandom_range(0, 19) == 0) ? SPARE_SEL :
              SEL_W'($urandom_range(0, STACKS - 1));
        case (kind)
          PH_FILL:  push_pct = 85;
          PH_DRAIN: push_pct = 15;
          PH_MIXED: push_pct = 50;
          default:  push_pct = (gen_used < SLOTS - 8) ? 90 : 50;
        endcase
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        queue_req(op, sel, rand_value(), drain && k == 0);
      end
    end

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for all requests, then all results, then a quiet tail
    while (req_backlog.size() != 0 || in_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
